FILE: hdl/apu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_pkg
// Shared types and constants of the moment-based parameter update block.
// ----------------------------------------------------------------------------
package apu_pkg;

  localparam int unsigned AddrW     = 12;
  localparam int unsigned ParamCnt  = 4096;
  localparam int unsigned GradW     = 16;
  localparam int unsigned GsqW      = 2 * GradW - 1;
  localparam int unsigned MomW      = 24;
  localparam int unsigned VarW      = 32;
  localparam int unsigned ChgW      = 24;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CmdDepth  = 4;
  localparam int unsigned OutDepth  = 32;
  localparam int unsigned CntW      = 6;
  localparam int unsigned RamW      = 1 + MomW + VarW;

  localparam logic [CfgIdxW-1:0] RegLr  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegB1  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegB2  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegEps = 2'd3;

  localparam logic OpUpdate = 1'b0;
  localparam logic OpClear  = 1'b1;

  typedef enum logic {
    CMD_UPDATE,
    CMD_CLEAR
  } cmd_kind_e;

  typedef enum logic {
    ST_SWEEP,
    ST_RUN
  } bk_state_e;

  typedef struct packed {
    logic                    op;
    logic [AddrW-1:0]        param_addr;
    logic signed [GradW-1:0] grad_value;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0]       out_addr;
    logic signed [ChgW-1:0] change_value;
  } out_item_t;

  typedef struct packed {
    logic [CfgW-1:0] lr;
    logic [CfgW-1:0] b1;
    logic [CfgW-1:0] b2;
    logic [CfgW-1:0] eps;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e               kind;
    logic [AddrW-1:0]        addr;
    logic signed [GradW-1:0] grad;
    logic [GsqW-1:0]         gsq;
  } cmd_t;

  typedef struct packed {
    logic  valid;
    cmd_t  cmd;
  } cmd_bus_t;

  typedef struct packed {
    logic            sweeping;
    logic            issue;
    logic [CntW-1:0] outq_cnt;
    logic [CntW-1:0] inflight;
  } bk_status_t;

  typedef struct packed {
    logic                   valid;
    logic signed [MomW-1:0] m;
    logic [VarW-1:0]        v;
  } ram_word_t;

endpackage

FILE: hdl/apu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module apu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/apu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_front
// Accepts items, classifies them and holds them in a short command queue.
// ----------------------------------------------------------------------------
module apu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full_o,
  input  apu_pkg::in_item_t   in_item_i,
  input  apu_pkg::bk_status_t status_i,
  output apu_pkg::cmd_bus_t   cmd_o,
  input  logic                cmd_pop_i
);

  localparam int unsigned PtrW = $clog2(apu_pkg::CmdDepth);

  apu_pkg::cmd_t          queue_q [apu_pkg::CmdDepth];
  logic [PtrW-1:0]        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]          cnt_q, cnt_d;
  logic                   accept;
  logic                   take;
  apu_pkg::cmd_t          cls;
  logic [apu_pkg::GradW-1:0] gmag;

  assign full_o = (cnt_q == (PtrW+1)'(apu_pkg::CmdDepth)) | status_i.sweeping;
  assign accept = push & ~full_o;
  assign take   = cmd_pop_i & (cnt_q != '0);

  // classify and square the gradient
  always_comb begin
    gmag      = in_item_i.grad_value[apu_pkg::GradW-1] ?
                apu_pkg::GradW'(-in_item_i.grad_value) :
                apu_pkg::GradW'(in_item_i.grad_value);
    cls.kind  = (in_item_i.op == apu_pkg::OpClear) ? apu_pkg::CMD_CLEAR :
                                                     apu_pkg::CMD_UPDATE;
    cls.addr  = in_item_i.param_addr;
    cls.grad  = in_item_i.grad_value;
    cls.gsq   = apu_pkg::GsqW'({{apu_pkg::GradW{1'b0}}, gmag} *
                               {{apu_pkg::GradW{1'b0}}, gmag});
  end

  always_comb begin
    wptr_d = wptr_q + PtrW'(accept);
    rptr_d = rptr_q + PtrW'(take);
    cnt_d  = cnt_q + (PtrW+1)'(accept) - (PtrW+1)'(take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      queue_q[wptr_q] <= cls;
    end
  end

  assign cmd_o.valid = (cnt_q != '0);
  assign cmd_o.cmd   = queue_q[rptr_q];

endmodule

FILE: hdl/apu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_back
// Moment update pipeline with state RAM, root and divide pipelines,
// clearing pass and result queue.
// ----------------------------------------------------------------------------
module apu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  apu_pkg::cfg_t       cfg_i,
  input  apu_pkg::cmd_bus_t   cmd_i,
  output logic                cmd_pop_o,
  output apu_pkg::bk_status_t status_o,
  output logic                empty,
  input  logic                pop,
  output apu_pkg::out_item_t  out_item_o
);

  localparam int unsigned AW    = apu_pkg::AddrW;
  localparam int unsigned SqSt  = 4;
  localparam int unsigned DvSt  = 6;
  localparam int unsigned OPtrW = $clog2(apu_pkg::OutDepth);

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [16:0] rem;
    logic [23:0] q;
  } dv_t;

  function automatic sq_t sqrt_steps(input sq_t s, input int unsigned base);
    sq_t         r;
    logic [31:0] bitv;
    logic [32:0] trial;
    r = s;
    for (int unsigned k = 0; k < 4; k++) begin
      bitv  = 32'(1) << (30 - 2 * (base + k));
      trial = {1'b0, r.root} + {1'b0, bitv};
      if ({1'b0, r.rem} >= trial) begin
        r.rem  = r.rem - trial[31:0];
        r.root = (r.root >> 1) + bitv;
      end else begin
        r.root = r.root >> 1;
      end
    end
    return r;
  endfunction

  function automatic dv_t div_steps(input dv_t s, input logic [23:0] nlow,
                                    input logic [16:0] dvs, input int unsigned base);
    dv_t         r;
    logic [17:0] t;
    int unsigned i;
    r = s;
    for (int unsigned k = 0; k < 4; k++) begin
      i = 23 - (base + k);
      t = {r.rem, nlow[i]};
      if (t >= {1'b0, dvs}) begin
        t      = t - {1'b0, dvs};
        r.q[i] = 1'b1;
      end
      r.rem = t[16:0];
    end
    return r;
  endfunction

  // control
  apu_pkg::bk_state_e state_q, state_d;
  logic [AW-1:0]      swp_q, swp_d;
  logic               sweeping, issue, clear_start, hazard, credit_ok;
  logic [apu_pkg::CntW-1:0] inflight_q, inflight_d;

  // stage 1 and 2
  logic                        s1_v_q, s2_v_q;
  logic [AW-1:0]               s1_addr_q, s2_addr_q;
  logic signed [apu_pkg::GradW-1:0] s1_g_q;
  logic [apu_pkg::GsqW-1:0]    s1_gsq_q;
  logic signed [23:0]          s2_m_q;
  logic [31:0]                 s2_v_q_val;
  logic signed [42:0]          s2_pm_q;
  logic signed [50:0]          s2_pv_q;

  // root pipeline
  logic            sq_v_q    [SqSt+1];
  sq_t             sq_q      [SqSt+1];
  logic [23:0]     sq_m_q    [SqSt+1];
  logic [AW-1:0]   sq_addr_q [SqSt+1];

  // multiply stage
  logic            md_v_q;
  logic [39:0]     md_num_q;
  logic [16:0]     md_d_q;
  logic            md_neg_q;
  logic [AW-1:0]   md_addr_q;

  // divide pipeline
  logic            dv_v_q    [DvSt+1];
  dv_t             dv_q      [DvSt+1];
  logic [23:0]     dv_nlow_q [DvSt+1];
  logic [16:0]     dv_d_q    [DvSt+1];
  logic            dv_ovf_q  [DvSt+1];
  logic            dv_zero_q [DvSt+1];
  logic            dv_neg_q  [DvSt+1];
  logic [AW-1:0]   dv_addr_q [DvSt+1];

  // result queue
  apu_pkg::out_item_t outq_q [apu_pkg::OutDepth];
  logic [OPtrW-1:0]   owp_q, orp_q;
  logic [apu_pkg::CntW-1:0] ocnt_q;
  logic               opush, otake;
  apu_pkg::out_item_t res;

  // RAM
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  apu_pkg::ram_word_t    ram_wword, ram_rword;
  logic [apu_pkg::RamW-1:0] ram_rdata;

  // datapath nets
  logic signed [23:0] m_rd, g24, m_new;
  logic [31:0]        v_rd, v_new;
  logic signed [24:0] dm;
  logic signed [32:0] dv_diff;
  logic [16:0]        f1, f2;
  logic signed [43:0] macc;
  logic signed [27:0] msh;
  logic [51:0]        vacc;
  logic [23:0]        mag, qmag;
  logic [35:0]        n2;
  logic [16:0]        hi;

  // ---------------------------------------------------------------- control
  assign sweeping  = (state_q == apu_pkg::ST_SWEEP);
  assign hazard    = (s1_v_q && s1_addr_q == cmd_i.cmd.addr) ||
                     (s2_v_q && s2_addr_q == cmd_i.cmd.addr);
  assign credit_ok = ({1'b0, ocnt_q} + {1'b0, inflight_q}) <
                     (apu_pkg::CntW+1)'(apu_pkg::OutDepth);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      apu_pkg::ST_SWEEP: if (swp_q == AW'(apu_pkg::ParamCnt - 1)) state_d = apu_pkg::ST_RUN;
      apu_pkg::ST_RUN:   if (clear_start) state_d = apu_pkg::ST_SWEEP;
      default:           state_d = apu_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    issue       = 1'b0;
    clear_start = 1'b0;
    unique case (state_q)
      apu_pkg::ST_RUN: begin
        issue       = cmd_i.valid && cmd_i.cmd.kind == apu_pkg::CMD_UPDATE &&
                      !hazard && credit_ok;
        clear_start = cmd_i.valid && cmd_i.cmd.kind == apu_pkg::CMD_CLEAR &&
                      !s1_v_q && !s2_v_q;
      end
      default: begin
        issue       = 1'b0;
        clear_start = 1'b0;
      end
    endcase
  end

  assign cmd_pop_o = issue | clear_start;
  assign swp_d     = sweeping ? swp_q + AW'(1) : swp_q;
  assign inflight_d = inflight_q + apu_pkg::CntW'(issue) - apu_pkg::CntW'(opush);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= apu_pkg::ST_SWEEP;
      swp_q      <= '0;
      inflight_q <= '0;
    end else begin
      state_q    <= state_d;
      swp_q      <= swp_d;
      inflight_q <= inflight_d;
    end
  end

  // -------------------------------------------------------------------- RAM
  always_comb begin
    ram_wword.valid = 1'b1;
    ram_wword.m     = m_new;
    ram_wword.v     = v_new;
    ram_we          = s2_v_q;
    ram_waddr       = s2_addr_q;
    if (sweeping) begin
      ram_wword = '0;
      ram_we    = 1'b1;
      ram_waddr = swp_q;
    end
  end

  apu_ram #(
    .Width (apu_pkg::RamW),
    .Depth (apu_pkg::ParamCnt)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wword),
    .raddr_i (cmd_i.cmd.addr),
    .rdata_o (ram_rdata)
  );

  assign ram_rword = ram_rdata;

  // ------------------------------------------------------ moment arithmetic
  always_comb begin
    m_rd    = ram_rword.valid ? ram_rword.m : '0;
    v_rd    = ram_rword.valid ? ram_rword.v : '0;
    g24     = {s1_g_q, 8'h00};
    dm      = $signed({g24[23], g24}) - $signed({m_rd[23], m_rd});
    dv_diff = $signed({2'b00, s1_gsq_q}) - $signed({1'b0, v_rd});
    f1      = 17'h10000 - {1'b0, cfg_i.b1};
    f2      = 17'h10000 - {1'b0, cfg_i.b2};
  end

  always_comb begin
    macc = $signed({{4{s2_m_q[23]}}, s2_m_q, 16'h0000}) +
           $signed({s2_pm_q[42], s2_pm_q}) + 44'sd32768;
    msh  = macc[43:16];
    if (msh > 28'sd8388607) begin
      m_new = 24'sh7FFFFF;
    end else if (msh < -28'sd8388608) begin
      m_new = 24'sh800000;
    end else begin
      m_new = msh[23:0];
    end
    vacc  = {4'h0, s2_v_q_val, 16'h0000} + {s2_pv_q[50], s2_pv_q} + 52'd32768;
    v_new = vacc[47:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= cmd_i.cmd.addr;
    s1_g_q     <= cmd_i.cmd.grad;
    s1_gsq_q   <= cmd_i.cmd.gsq;
    s2_addr_q  <= s1_addr_q;
    s2_m_q     <= m_rd;
    s2_v_q_val <= v_rd;
    s2_pm_q    <= $signed({1'b0, f1}) * dm;
    s2_pv_q    <= $signed({1'b0, f2}) * dv_diff;
  end

  // ------------------------------------------------------------------- root
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= SqSt; i++) sq_v_q[i] <= 1'b0;
    end else begin
      sq_v_q[0] <= s2_v_q;
      for (int i = 0; i < SqSt; i++) sq_v_q[i+1] <= sq_v_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q[0].rem  <= v_new;
    sq_q[0].root <= '0;
    sq_m_q[0]    <= m_new;
    sq_addr_q[0] <= s2_addr_q;
    for (int i = 0; i < SqSt; i++) begin
      sq_q[i+1]      <= sqrt_steps(sq_q[i], 4 * i);
      sq_m_q[i+1]    <= sq_m_q[i];
      sq_addr_q[i+1] <= sq_addr_q[i];
    end
  end

  // --------------------------------------------------------------- multiply
  assign mag = sq_m_q[SqSt][23] ? 24'(-sq_m_q[SqSt]) : sq_m_q[SqSt];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_v_q <= 1'b0;
    end else begin
      md_v_q <= sq_v_q[SqSt];
    end
  end

  always_ff @(posedge clk_i) begin
    md_num_q  <= {24'h0, cfg_i.lr} * {16'h0, mag};
    md_d_q    <= {1'b0, sq_q[SqSt].root[15:0]} + {1'b0, cfg_i.eps};
    md_neg_q  <= sq_m_q[SqSt][23];
    md_addr_q <= sq_addr_q[SqSt];
  end

  // ----------------------------------------------------------------- divide
  assign n2 = md_num_q[39:4];
  assign hi = {5'h00, n2[35:24]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DvSt; i++) dv_v_q[i] <= 1'b0;
    end else begin
      dv_v_q[0] <= md_v_q;
      for (int i = 0; i < DvSt; i++) dv_v_q[i+1] <= dv_v_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q[0].rem  <= hi;
    dv_q[0].q    <= '0;
    dv_nlow_q[0] <= n2[23:0];
    dv_d_q[0]    <= md_d_q;
    dv_ovf_q[0]  <= (hi >= md_d_q);
    dv_zero_q[0] <= (md_num_q == '0);
    dv_neg_q[0]  <= md_neg_q;
    dv_addr_q[0] <= md_addr_q;
    for (int i = 0; i < DvSt; i++) begin
      dv_q[i+1]      <= div_steps(dv_q[i], dv_nlow_q[i], dv_d_q[i], 4 * i);
      dv_nlow_q[i+1] <= dv_nlow_q[i];
      dv_d_q[i+1]    <= dv_d_q[i];
      dv_ovf_q[i+1]  <= dv_ovf_q[i];
      dv_zero_q[i+1] <= dv_zero_q[i];
      dv_neg_q[i+1]  <= dv_neg_q[i];
      dv_addr_q[i+1] <= dv_addr_q[i];
    end
  end

  always_comb begin
    qmag = (dv_ovf_q[DvSt] || dv_q[DvSt].q > 24'h800000) ? 24'h800000 : dv_q[DvSt].q;
    res.out_addr = dv_addr_q[DvSt];
    if (dv_zero_q[DvSt]) begin
      res.change_value = '0;
    end else if (dv_neg_q[DvSt]) begin
      res.change_value = 24'(-qmag);
    end else if (qmag == 24'h800000) begin
      res.change_value = 24'sh7FFFFF;
    end else begin
      res.change_value = qmag;
    end
  end

  // ----------------------------------------------------------- result queue
  assign opush = dv_v_q[DvSt];
  assign otake = pop & ~empty;
  assign empty = (ocnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      owp_q  <= owp_q + OPtrW'(opush);
      orp_q  <= orp_q + OPtrW'(otake);
      ocnt_q <= ocnt_q + apu_pkg::CntW'(opush) - apu_pkg::CntW'(otake);
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      outq_q[owp_q] <= res;
    end
  end

  assign out_item_o = outq_q[orp_q];

  assign status_o.sweeping = sweeping;
  assign status_o.issue    = issue;
  assign status_o.outq_cnt = ocnt_q;
  assign status_o.inflight = inflight_q;

endmodule

FILE: hdl/adam_parameter_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_parameter_update
// Throughput: one update per cycle while the result queue has room for it
// and for all updates in flight; an update to the same address as one of
// the two before it waits until that one has written the moment RAM.
// A clear item sweeps all 4096 moment RAM entries, one entry a cycle.
// Reset starts the same pass; full stays high until it is done.
// ----------------------------------------------------------------------------
module adam_parameter_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  apu_pkg::in_item_t             in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output apu_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [apu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [apu_pkg::CfgW-1:0]      cfg_wdata_i
);

  apu_pkg::cfg_t       cfg_q, cfg_d;
  apu_pkg::cmd_bus_t   cmd;
  apu_pkg::bk_status_t st;
  logic                cmd_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        apu_pkg::RegLr:  cfg_d.lr  = cfg_wdata_i;
        apu_pkg::RegB1:  cfg_d.b1  = cfg_wdata_i;
        apu_pkg::RegB2:  cfg_d.b2  = cfg_wdata_i;
        apu_pkg::RegEps: cfg_d.eps = cfg_wdata_i;
        default:         cfg_d     = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lr  <= 16'd66;
      cfg_q.b1  <= 16'd58982;
      cfg_q.b2  <= 16'd65470;
      cfg_q.eps <= 16'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  apu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full_o    (full),
    .in_item_i (in_item_i),
    .status_i  (st),
    .cmd_o     (cmd),
    .cmd_pop_i (cmd_pop)
  );

  apu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .status_o   (st),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  a_credit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, st.outq_cnt} + {1'b0, st.inflight}) <= 7'd32)
    else $error("result queue overcommitted");

  a_no_issue_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.sweeping |-> !st.issue)
    else $error("update issued during clearing pass");

  a_full_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.sweeping |-> full)
    else $error("input open during clearing pass");

endmodule
